// ===== rtl/vtenc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VT escape sequence encoder package
// Shared widths, codes, the colour tables and the control-store program.
// ----------------------------------------------------------------------------
package vtenc_pkg;

    localparam int SDataW = 48;
    localparam int SUserW = 4;
    localparam int ByteW  = 8;
    localparam int ValW   = 17;
    localparam int DigitMax = 5;
    localparam int PcW    = 6;
    localparam int RecipW = 16;
    localparam int RecipShift = 19;
    localparam logic [RecipW-1:0] Recip10 = 16'd52429;

    localparam logic [2:0] MODE_CLEAR   = 3'd0;
    localparam logic [2:0] MODE_CURSOR  = 3'd1;
    localparam logic [2:0] MODE_TEXT    = 3'd2;
    localparam logic [2:0] MODE_PEN     = 3'd3;
    localparam logic [2:0] MODE_VISIBLE = 3'd4;
    localparam logic [2:0] MODE_ALT     = 3'd5;
    localparam logic [2:0] MODE_IGNORE  = 3'd6;
    localparam logic [2:0] MODE_FORGET  = 3'd7;

    localparam logic [ByteW-1:0] CH_ESC   = 8'h1B;
    localparam logic [ByteW-1:0] CH_LBRK  = 8'h5B;
    localparam logic [ByteW-1:0] CH_SEMI  = 8'h3B;
    localparam logic [ByteW-1:0] CH_QUERY = 8'h3F;
    localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
    localparam logic [ByteW-1:0] CH_ONE   = 8'h31;
    localparam logic [ByteW-1:0] CH_TWO   = 8'h32;
    localparam logic [ByteW-1:0] CH_FOUR  = 8'h34;
    localparam logic [ByteW-1:0] CH_FIVE  = 8'h35;
    localparam logic [ByteW-1:0] CH_NINE  = 8'h39;
    localparam logic [ByteW-1:0] CH_UP_H  = 8'h48;
    localparam logic [ByteW-1:0] CH_UP_J  = 8'h4A;
    localparam logic [ByteW-1:0] CH_LO_H  = 8'h68;
    localparam logic [ByteW-1:0] CH_LO_L  = 8'h6C;
    localparam logic [ByteW-1:0] CH_LO_M  = 8'h6D;

    // Entry points of the programs held in the control store.
    localparam logic [PcW-1:0] PC_CLEAR   = 6'd0;
    localparam logic [PcW-1:0] PC_CURSOR  = 6'd7;
    localparam logic [PcW-1:0] PC_PEN     = 6'd15;
    localparam logic [PcW-1:0] PC_VISIBLE = 6'd25;
    localparam logic [PcW-1:0] PC_ALT     = 6'd31;
    localparam logic [PcW-1:0] PC_TEXT    = 6'd39;
    localparam logic [PcW-1:0] PROG_LEN   = 6'd40;

    typedef enum logic [1:0] {SEL_LIT, SEL_DIGIT, SEL_TEXT, SEL_HL} byte_sel_t;
    typedef enum logic [2:0] {SRC_NONE, SRC_ROW, SRC_COL, SRC_FG, SRC_BG} val_src_t;
    typedef enum logic [1:0] {COND_NONE, COND_QUOT_NZ, COND_MORE} loop_cond_t;

    // One control word. A step whose condition holds repeats itself; a step
    // marked last ends the program.
    typedef struct packed {
        logic             emit;
        byte_sel_t        sel;
        logic [ByteW-1:0] lit;
        logic             last;
        val_src_t         src;
        logic             divide;
        loop_cond_t       cond;
    } uword_t;

    typedef struct packed {
        logic            load;
        logic [ValW-1:0] value;
        logic            divide;
        logic            pop;
    } dig_ctrl_t;

    typedef struct packed {
        logic       quot_nz;
        logic       more;
        logic [3:0] digit;
    } dig_stat_t;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
    } out_beat_t;

    function automatic uword_t mk(input logic emit, input byte_sel_t sel,
                                  input logic [ByteW-1:0] lit, input logic last,
                                  input val_src_t src, input logic divide,
                                  input loop_cond_t cond);
        uword_t w;
        w.emit   = emit;
        w.sel    = sel;
        w.lit    = lit;
        w.last   = last;
        w.src    = src;
        w.divide = divide;
        w.cond   = cond;
        return w;
    endfunction

    function automatic uword_t lit_w(input logic [ByteW-1:0] ch);
        return mk(1'b1, SEL_LIT, ch, 1'b0, SRC_NONE, 1'b0, COND_NONE);
    endfunction

    function automatic uword_t lit_ld_w(input logic [ByteW-1:0] ch, input val_src_t src);
        return mk(1'b1, SEL_LIT, ch, 1'b0, src, 1'b0, COND_NONE);
    endfunction

    function automatic uword_t end_w(input byte_sel_t sel, input logic [ByteW-1:0] ch);
        return mk(1'b1, sel, ch, 1'b1, SRC_NONE, 1'b0, COND_NONE);
    endfunction

    function automatic uword_t div_w();
        return mk(1'b0, SEL_LIT, CH_ZERO, 1'b0, SRC_NONE, 1'b1, COND_QUOT_NZ);
    endfunction

    function automatic uword_t pop_w();
        return mk(1'b1, SEL_DIGIT, CH_ZERO, 1'b0, SRC_NONE, 1'b0, COND_MORE);
    endfunction

    // Control store: clear, cursor, pen, cursor visibility, alternate screen, text.
    function automatic uword_t ucode(input logic [PcW-1:0] pc);
        uword_t w;
        unique case (pc)
            6'd0:  w = lit_w(CH_ESC);
            6'd1:  w = lit_w(CH_LBRK);
            6'd2:  w = lit_w(CH_TWO);
            6'd3:  w = lit_w(CH_UP_J);
            6'd4:  w = lit_w(CH_ESC);
            6'd5:  w = lit_w(CH_LBRK);
            6'd6:  w = end_w(SEL_LIT, CH_UP_H);
            6'd7:  w = lit_ld_w(CH_ESC, SRC_ROW);
            6'd8:  w = lit_w(CH_LBRK);
            6'd9:  w = div_w();
            6'd10: w = pop_w();
            6'd11: w = lit_ld_w(CH_SEMI, SRC_COL);
            6'd12: w = div_w();
            6'd13: w = pop_w();
            6'd14: w = end_w(SEL_LIT, CH_UP_H);
            6'd15: w = lit_ld_w(CH_ESC, SRC_FG);
            6'd16: w = lit_w(CH_LBRK);
            6'd17: w = lit_w(CH_ZERO);
            6'd18: w = lit_w(CH_SEMI);
            6'd19: w = div_w();
            6'd20: w = pop_w();
            6'd21: w = lit_ld_w(CH_SEMI, SRC_BG);
            6'd22: w = div_w();
            6'd23: w = pop_w();
            6'd24: w = end_w(SEL_LIT, CH_LO_M);
            6'd25: w = lit_w(CH_ESC);
            6'd26: w = lit_w(CH_LBRK);
            6'd27: w = lit_w(CH_QUERY);
            6'd28: w = lit_w(CH_TWO);
            6'd29: w = lit_w(CH_FIVE);
            6'd30: w = end_w(SEL_HL, CH_LO_H);
            6'd31: w = lit_w(CH_ESC);
            6'd32: w = lit_w(CH_LBRK);
            6'd33: w = lit_w(CH_QUERY);
            6'd34: w = lit_w(CH_ONE);
            6'd35: w = lit_w(CH_ZERO);
            6'd36: w = lit_w(CH_FOUR);
            6'd37: w = lit_w(CH_NINE);
            6'd38: w = end_w(SEL_HL, CH_LO_H);
            6'd39: w = end_w(SEL_TEXT, CH_ZERO);
            // Unused addresses end the program quietly.
            default: w = mk(1'b0, SEL_LIT, CH_ZERO, 1'b1, SRC_NONE, 1'b0, COND_NONE);
        endcase
        return w;
    endfunction

    // Foreground index fourteen deliberately maps to plain 33.
    function automatic logic [6:0] fg_code(input logic [3:0] idx);
        logic [6:0] c;
        unique case (idx)
            4'd0:  c = 7'd30;
            4'd1:  c = 7'd34;
            4'd2:  c = 7'd32;
            4'd3:  c = 7'd36;
            4'd4:  c = 7'd31;
            4'd5:  c = 7'd35;
            4'd6:  c = 7'd33;
            4'd7:  c = 7'd37;
            4'd8:  c = 7'd90;
            4'd9:  c = 7'd94;
            4'd10: c = 7'd92;
            4'd11: c = 7'd96;
            4'd12: c = 7'd91;
            4'd13: c = 7'd95;
            4'd14: c = 7'd33;
            default: c = 7'd97;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] bg_code(input logic [2:0] idx);
        logic [5:0] c;
        unique case (idx)
            3'd0: c = 6'd40;
            3'd1: c = 6'd44;
            3'd2: c = 6'd42;
            3'd3: c = 6'd46;
            3'd4: c = 6'd41;
            3'd5: c = 6'd45;
            3'd6: c = 6'd43;
            default: c = 6'd47;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/vtenc_digit_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VT encoder decimal digit unit
// Splits a value into decimal digits, one per cycle, and returns them
// most significant first from a small digit stack.
// ----------------------------------------------------------------------------
module vtenc_digit_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vtenc_pkg::dig_ctrl_t ctrl,
    output vtenc_pkg::dig_stat_t stat
);
    import vtenc_pkg::*;

    localparam int CntW = $clog2(DigitMax + 1);
    localparam int IdxW = $clog2(DigitMax);

    logic [ValW-1:0]        value_reg;
    logic [ValW-1:0]        value_next;
    logic [CntW-1:0]        count_reg;
    logic [CntW-1:0]        count_next;
    logic [3:0]             stack_reg [DigitMax];
    logic [ValW+RecipW-1:0] prod;
    logic [ValW-1:0]        quot;
    logic [ValW-1:0]        rem;
    logic [IdxW-1:0]        top_idx;

    // Quotient by ten through the reciprocal; exact for every value held here.
    assign prod    = value_reg * Recip10;
    assign quot    = ValW'(prod >> RecipShift);
    assign rem     = value_reg - ((quot << 3) + (quot << 1));
    assign top_idx = IdxW'(count_reg - 1'b1);

    always_comb
    begin
        value_next = value_reg;
        count_next = count_reg;
        if (ctrl.load)
        begin
            value_next = ctrl.value;
            count_next = '0;
        end
        else if (ctrl.divide)
        begin
            value_next = quot;
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (ctrl.divide && !ctrl.load)
        begin
            stack_reg[count_reg[IdxW-1:0]] <= rem[3:0];
        end
    end

    assign stat.quot_nz = (quot != '0);
    assign stat.more    = (count_reg > CntW'(1));
    assign stat.digit   = stack_reg[top_idx];

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.divide |-> count_reg < CntW'(DigitMax))
        else $error("digit stack overflow");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> count_reg != '0)
        else $error("digit popped from an empty stack");

    a_load_alone: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |-> !ctrl.divide && !ctrl.pop)
        else $error("value load combined with a digit operation");

endmodule

// ===== rtl/vtenc_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VT encoder output stage
// One registered byte slot on the master side of the stream.
// ----------------------------------------------------------------------------
module vtenc_out_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  vtenc_pkg::out_beat_t                beat,
    output logic                                free,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [vtenc_pkg::ByteW-1:0]         m_tdata,   // [7:0] out_byte
    output logic                                m_tlast
);
    import vtenc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_beat_t beat_reg;

    // The slot can take a new byte when empty or when its byte leaves now.
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= beat;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = beat_reg.data;
    assign m_tlast  = beat_reg.last;

endmodule

// ===== rtl/vt_escape_sequence_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VT escape sequence encoder core
// Turns one console operation per transfer into the ANSI/VT byte stream,
// driven by a small microprogram held in a read-only control store.
// ----------------------------------------------------------------------------
// Usage. Each slave-side transfer carries one operation: the mode and the
// text-present flag in s_tuser, the cursor row and column, text byte, colour
// indexes and enable flag in s_tdata. The master side delivers the resulting
// bytes one per transfer, with m_tlast on the final byte of each operation.
// Operations that produce no bytes (repeated cursor, empty text, the ignored
// property, forget position) complete in the cycle they are accepted.
// Sequencing. An operation that produces bytes occupies the sequencer from
// acceptance through each microprogram step; each decimal number takes one
// step per digit to split it off and one step per digit to send it. The
// first byte is loaded into the output register by the first program step,
// once the output register can take it. A new operation is accepted as soon
// as the previous program has handed its last byte to the output register.
// Reset clears the sequencer, empties the output register and marks the
// cursor position unknown. When the receiver stalls, the output register
// holds its byte and the sequencer waits on its next byte-producing step.
// ----------------------------------------------------------------------------
module vt_escape_sequence_encoder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] row, [31:16] col, [39:32] text_byte, [43:40] fg_index,
    // [46:44] bg_index, [47] enable
    input  logic [vtenc_pkg::SDataW-1:0]  s_tdata,
    // [2:0] mode, [3] text_present
    input  logic [vtenc_pkg::SUserW-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vtenc_pkg::ByteW-1:0]   m_tdata,   // [7:0] out_byte
    output logic                          m_tlast
);
    import vtenc_pkg::*;

    // Fields of the incoming operation.
    logic [2:0]  in_mode;
    logic        in_text_present;
    logic [15:0] in_row;
    logic [15:0] in_col;
    logic [7:0]  in_text_byte;
    logic [3:0]  in_fg_index;
    logic [2:0]  in_bg_index;
    logic        in_enable;

    assign in_mode         = s_tuser[2:0];
    assign in_text_present = s_tuser[3];
    assign in_row          = s_tdata[15:0];
    assign in_col          = s_tdata[31:16];
    assign in_text_byte    = s_tdata[39:32];
    assign in_fg_index     = s_tdata[43:40];
    assign in_bg_index     = s_tdata[46:44];
    assign in_enable       = s_tdata[47];

    // Sequencer and cursor-tracking state.
    logic           busy_reg, busy_next;
    logic [PcW-1:0] pc_reg, pc_next;
    logic [15:0]    emitted_row_reg, emitted_row_next;
    logic [15:0]    emitted_col_reg, emitted_col_next;
    logic           known_reg, known_next;

    // Operands held for the running program.
    logic [ValW-1:0] row1_reg;
    logic [ValW-1:0] col1_reg;
    logic [7:0]      text_reg;
    logic [6:0]      fgv_reg;
    logic [5:0]      bgv_reg;
    logic            en_reg;

    logic           accept;
    logic           start_run;
    logic [PcW-1:0] start_pc;
    logic           repeat_pos;
    uword_t         word;
    logic           out_free;
    logic           fire;
    logic           loop_hit;
    logic           out_load;
    out_beat_t      beat;
    dig_ctrl_t      dctl;
    dig_stat_t      dstat;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign word     = ucode(pc_reg);

    // A step runs when it sends nothing or the output slot can take its byte.
    assign fire     = busy_reg && (!word.emit || out_free);
    assign out_load = fire && word.emit;

    assign repeat_pos = known_reg && (in_row == emitted_row_reg)
                        && (in_col == emitted_col_reg);

    // Dispatch: choose the program and update the cursor baseline on acceptance.
    always_comb
    begin
        start_run        = 1'b0;
        start_pc         = PC_TEXT;
        emitted_row_next = emitted_row_reg;
        emitted_col_next = emitted_col_reg;
        known_next       = known_reg;
        unique case (in_mode)
            MODE_CLEAR:
            begin
                start_run        = 1'b1;
                start_pc         = PC_CLEAR;
                emitted_row_next = '0;
                emitted_col_next = '0;
                known_next       = 1'b1;
            end
            MODE_CURSOR:
            begin
                if (!repeat_pos)
                begin
                    start_run        = 1'b1;
                    start_pc         = PC_CURSOR;
                    emitted_row_next = in_row;
                    emitted_col_next = in_col;
                    known_next       = 1'b1;
                end
            end
            MODE_TEXT:
            begin
                start_run = in_text_present;
                start_pc  = PC_TEXT;
            end
            MODE_PEN:
            begin
                start_run = 1'b1;
                start_pc  = PC_PEN;
            end
            MODE_VISIBLE:
            begin
                start_run = 1'b1;
                start_pc  = PC_VISIBLE;
            end
            MODE_ALT:
            begin
                start_run = 1'b1;
                start_pc  = PC_ALT;
            end
            MODE_IGNORE:
            begin
                start_run = 1'b0;
            end
            MODE_FORGET:
            begin
                emitted_row_next = '0;
                emitted_col_next = '0;
                known_next       = 1'b0;
            end
            default:
            begin
                start_run = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (word.cond)
            COND_QUOT_NZ: loop_hit = dstat.quot_nz;
            COND_MORE:    loop_hit = dstat.more;
            default:      loop_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (accept)
        begin
            busy_next = start_run;
            pc_next   = start_pc;
        end
        else if (fire)
        begin
            if (word.last)
            begin
                busy_next = 1'b0;
            end
            else if (!loop_hit)
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            pc_reg          <= '0;
            emitted_row_reg <= '0;
            emitted_col_reg <= '0;
            known_reg       <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            if (accept)
            begin
                emitted_row_reg <= emitted_row_next;
                emitted_col_reg <= emitted_col_next;
                known_reg       <= known_next;
            end
        end
    end

    // Operand capture; numbers are held already offset or translated.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row1_reg <= ValW'(in_row) + 1'b1;
            col1_reg <= ValW'(in_col) + 1'b1;
            text_reg <= in_text_byte;
            fgv_reg  <= fg_code(in_fg_index);
            bgv_reg  <= bg_code(in_bg_index);
            en_reg   <= in_enable;
        end
    end

    // Digit unit control from the current control word.
    always_comb
    begin
        dctl.load   = fire && (word.src != SRC_NONE);
        dctl.divide = fire && word.divide;
        dctl.pop    = out_load && (word.sel == SEL_DIGIT);
        case (word.src)
            SRC_ROW: dctl.value = row1_reg;
            SRC_COL: dctl.value = col1_reg;
            SRC_FG:  dctl.value = ValW'(fgv_reg);
            SRC_BG:  dctl.value = ValW'(bgv_reg);
            default: dctl.value = '0;
        endcase
    end

    // Byte selection for the output slot.
    always_comb
    begin
        beat.last = word.last;
        case (word.sel)
            SEL_DIGIT: beat.data = CH_ZERO + ByteW'(dstat.digit);
            SEL_TEXT:  beat.data = text_reg;
            SEL_HL:    beat.data = en_reg ? CH_LO_H : CH_LO_L;
            default:   beat.data = word.lit;
        endcase
    end

    vtenc_digit_unit u_digit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dctl),
        .stat  (dstat)
    );

    vtenc_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .beat     (beat),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg < PROG_LEN)
        else $error("sequencer outside the control store");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && word.last) |=> !busy_reg)
        else $error("sequencer still busy after the final step");

    a_pop_sends: assert property (@(posedge clk) disable iff (!rst_n)
        dctl.pop |-> out_load && busy_reg)
        else $error("digit consumed without being sent");

endmodule

// ===== tb/vt_escape_sequence_encoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VT escape sequence encoder core testbench
// Sends console operations into the encoder and checks every byte against an
// independent encoder model or a reply typed in by hand. The model tracks the
// last cursor position it sent. A short directed script covers each mode, the
// number extremes and the cases that produce no bytes. A weighted random
// stream follows, and both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module vt_escape_sequence_encoder_core_tb;

    import vtenc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_OPS   = 500;
    localparam int TAIL_CYCLES  = 40;

    // Colour codes for the indexed pens. Foreground fourteen is plain 33 on
    // purpose, not the bright 93 that the pattern of the table would suggest.
    localparam int FG_CODES [16] = '{30, 34, 32, 36, 31, 35, 33, 37,
                                     90, 94, 92, 96, 91, 95, 33, 97};
    localparam int BG_CODES [8]  = '{40, 44, 42, 46, 41, 45, 43, 47};

    // One console operation. Rows of the directed script may carry the exact
    // reply typed in by hand; the model still runs on them so that its cursor
    // state stays in step with the block.
    typedef struct {
        logic [2:0]  mode;
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  tbyte;
        logic        tpres;
        logic [3:0]  fg;
        logic [2:0]  bg;
        logic        en;
        bit          typed;
        string       reply;
    } console_op_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [SDataW-1:0]   s_tdata;   // [15:0] row, [31:16] col, [39:32] text_byte,
                                    // [43:40] fg_index, [46:44] bg_index, [47] enable
    logic [SUserW-1:0]   s_tuser;   // [2:0] mode, [3] text_present
    logic                m_tvalid;
    logic                m_tready;
    logic [ByteW-1:0]    m_tdata;   // [7:0] out_byte
    logic                m_tlast;

    // Cursor position as the model last sent it.
    logic [15:0] sent_row;
    logic [15:0] sent_col;
    logic        sent_known;

    out_beat_t   pending_beats[$];
    out_beat_t   want_beat;
    console_op_t script[$];

    bit          calm;
    int          err_count;
    int          cycle_count;
    int          ops_sent;
    int          bytes_checked;
    int          silent_ops;

    vt_escape_sequence_encoder_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // Encoder model: the bytes one operation produces, with the cursor state
    // updated as a side effect.
    function automatic void encode_op(input console_op_t op, output logic [7:0] seq[$]);
        string txt;
        txt = "";
        seq.delete();
        case (op.mode)
            MODE_CLEAR:
            begin
                txt        = "\033[2J\033[H";
                sent_row   = '0;
                sent_col   = '0;
                sent_known = 1'b1;
            end
            MODE_CURSOR:
            begin
                // A request for the cell already sent produces nothing.
                if (!(sent_known && op.row == sent_row && op.col == sent_col))
                begin
                    txt = $sformatf("\033[%0d;%0dH", int'(op.row) + 1, int'(op.col) + 1);
                    sent_row   = op.row;
                    sent_col   = op.col;
                    sent_known = 1'b1;
                end
            end
            MODE_TEXT:
            begin
                // Pushed directly: a zero byte cannot live in a string.
                if (op.tpres)
                    seq.push_back(op.tbyte);
            end
            MODE_PEN:
                txt = $sformatf("\033[0;%0d;%0dm", FG_CODES[op.fg], BG_CODES[op.bg]);
            MODE_VISIBLE:
                txt = op.en ? "\033[?25h" : "\033[?25l";
            MODE_ALT:
                txt = op.en ? "\033[?1049h" : "\033[?1049l";
            MODE_IGNORE:
                txt = "";
            MODE_FORGET:
            begin
                sent_row   = '0;
                sent_col   = '0;
                sent_known = 1'b0;
            end
            default:
                txt = "";
        endcase
        for (int i = 0; i < txt.len(); i++)
            seq.push_back(txt[i]);
    endfunction

    // Idle gaps: mostly none, some short, a few long. A calm stretch turns
    // them off on both sides.
    function automatic int unsigned pick_gap(input int unsigned longest);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, longest);
    endfunction

    function automatic logic [15:0] pick_coord();
        int unsigned r;
        logic [15:0] edges [10];
        edges = '{16'd0, 16'd8, 16'd9, 16'd98, 16'd99, 16'd998, 16'd999,
                  16'd9998, 16'd9999, 16'd65534};
        r = $urandom_range(0, 99);
        if (r < 55)
            return 16'($urandom_range(0, 15));
        if (r < 75)
            return 16'($urandom_range(0, 65534));
        return edges[$urandom_range(0, 9)];
    endfunction

    // Random operation. Every field is filled with noise first, so the
    // fields a mode does not use still toggle, and then the mode is chosen
    // with cursor moves and text weighted highest.
    function automatic console_op_t random_op();
        console_op_t op;
        int unsigned r;
        op.row   = 16'($urandom_range(0, 65534));
        op.col   = 16'($urandom_range(0, 65534));
        op.tbyte = 8'($urandom_range(0, 255));
        op.tpres = 1'($urandom_range(0, 1));
        op.fg    = 4'($urandom_range(0, 15));
        op.bg    = 3'($urandom_range(0, 7));
        op.en    = 1'($urandom_range(0, 1));
        op.typed = 1'b0;
        op.reply = "";
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            op.mode = MODE_CURSOR;
            // Revisit the last cell often so that suppression is exercised.
            if ($urandom_range(0, 99) < 30)
            begin
                op.row = sent_row;
                op.col = sent_col;
            end
            else
            begin
                op.row = pick_coord();
                op.col = pick_coord();
            end
        end
        else if (r < 50)
        begin
            op.mode  = MODE_TEXT;
            op.tpres = ($urandom_range(0, 99) < 85);
        end
        else if (r < 65)
            op.mode = MODE_PEN;
        else if (r < 72)
            op.mode = MODE_VISIBLE;
        else if (r < 79)
            op.mode = MODE_ALT;
        else if (r < 86)
            op.mode = MODE_IGNORE;
        else if (r < 92)
            op.mode = MODE_FORGET;
        else
            op.mode = MODE_CLEAR;
        return op;
    endfunction

    // Presents one operation and holds it until the block takes it. The
    // expected bytes are queued at the edge where the transfer happens.
    // s_tvalid is only lowered when a gap follows, so a back-to-back operation
    // never sees it lowered and raised in the same step.
    task automatic send_op(input console_op_t op);
        logic [7:0]  seq[$];
        int unsigned gap;
        gap = pick_gap(32);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {op.en, op.bg, op.fg, op.tbyte, op.col, op.row};
        s_tuser  <= {op.tpres, op.mode};
        do
            @(posedge clk);
        while (!s_tready);
        encode_op(op, seq);
        if (op.typed)
        begin
            seq.delete();
            for (int i = 0; i < op.reply.len(); i++)
                seq.push_back(op.reply[i]);
        end
        if (seq.size() == 0)
            silent_ops++;
        foreach (seq[i])
            pending_beats.push_back('{data: seq[i], last: (i == seq.size() - 1)});
        ops_sent++;
    endtask

    // Stops sending until every queued byte has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: ready in runs, with stalls of random length between them.
    initial
    begin
        int unsigned stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap(24);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Every byte transfer is checked against the oldest expected byte.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                err_count++;
                $display("%0t: byte 0x%02h last %0b with nothing expected",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want_beat = pending_beats.pop_front();
                bytes_checked++;
                if (m_tdata !== want_beat.data)
                begin
                    err_count++;
                    $display("%0t: out_byte expected 0x%02h, got 0x%02h",
                             $time, want_beat.data, m_tdata);
                end
                if (m_tlast !== want_beat.last)
                begin
                    err_count++;
                    $display("%0t: last expected %0b, got %0b",
                             $time, want_beat.last, m_tlast);
                end
            end
        end
    end

    // Watchdog, far above the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d bytes outstanding", $time, pending_beats.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        calm          = 1'b0;
        err_count     = 0;
        cycle_count   = 0;
        ops_sent      = 0;
        bytes_checked = 0;
        silent_ops    = 0;
        sent_row      = '0;
        sent_col      = '0;
        sent_known    = 1'b0;

        // Directed script. Columns: mode, row, col, text byte, text present,
        // fg, bg, enable, reply typed in, reply.
        script = '{
            // Straight after reset the position is unknown, so 0,0 is sent.
            '{MODE_CURSOR,  16'd0,     16'd0,     8'h00, 1'b0, 4'd0,  3'd0, 1'b0, 1'b1, "\033[1;1H"},
            '{MODE_CURSOR,  16'd0,     16'd0,     8'hFF, 1'b1, 4'd15, 3'd7, 1'b1, 1'b1, ""},
            '{MODE_FORGET,  16'd0,     16'd0,     8'h00, 1'b0, 4'd0,  3'd0, 1'b0, 1'b1, ""},
            '{MODE_CURSOR,  16'd0,     16'd0,     8'h00, 1'b0, 4'd0,  3'd0, 1'b0, 1'b1, "\033[1;1H"},
            '{MODE_CLEAR,   16'd65534, 16'd65534, 8'hFF, 1'b1, 4'd15, 3'd7, 1'b1, 1'b1,
              "\033[2J\033[H"},
            // Clear leaves the cursor known at the home cell.
            '{MODE_CURSOR,  16'd0,     16'd0,     8'h00, 1'b0, 4'd0,  3'd0, 1'b0, 1'b1, ""},
            // The longest reply of all: fourteen bytes.
            '{MODE_CURSOR,  16'd65534, 16'd65534, 8'h00, 1'b0, 4'd0,  3'd0, 1'b0, 1'b1,
              "\033[65535;65535H"},
            '{MODE_CURSOR,  16'd65534, 16'd65534, 8'h00, 1'b0, 4'd0,  3'd0, 1'b0, 1'b1, ""},
            '{MODE_CURSOR,  16'd9,     16'd99,    8'h5A, 1'b1, 4'd3,  3'd2, 1'b1, 1'b0, ""},
            '{MODE_CURSOR,  16'd65534, 16'd0,     8'hA5, 1'b0, 4'd12, 3'd5, 1'b0, 1'b0, ""},
            '{MODE_TEXT,    16'd65534, 16'd65534, 8'hFF, 1'b1, 4'd15, 3'd7, 1'b1, 1'b1, "\377"},
            // Empty text produces nothing.
            '{MODE_TEXT,    16'd0,     16'd0,     8'h41, 1'b0, 4'd0,  3'd0, 1'b0, 1'b1, ""},
            '{MODE_TEXT,    16'd1234,  16'd4321,  8'h00, 1'b1, 4'd7,  3'd3, 1'b0, 1'b0, ""},
            '{MODE_PEN,     16'd0,     16'd0,     8'h00, 1'b0, 4'd0,  3'd0, 1'b0, 1'b1,
              "\033[0;30;40m"},
            '{MODE_PEN,     16'd65534, 16'd65534, 8'hFF, 1'b1, 4'd15, 3'd7, 1'b1, 1'b1,
              "\033[0;97;47m"},
            // Foreground fourteen stays at plain yellow.
            '{MODE_PEN,     16'd0,     16'd0,     8'h00, 1'b0, 4'd14, 3'd3, 1'b0, 1'b1,
              "\033[0;33;46m"},
            '{MODE_PEN,     16'd7,     16'd7,     8'h33, 1'b1, 4'd8,  3'd5, 1'b1, 1'b0, ""},
            '{MODE_VISIBLE, 16'd0,     16'd0,     8'h00, 1'b0, 4'd0,  3'd0, 1'b1, 1'b1, "\033[?25h"},
            '{MODE_VISIBLE, 16'd65534, 16'd65534, 8'hFF, 1'b1, 4'd15, 3'd7, 1'b0, 1'b1, "\033[?25l"},
            '{MODE_ALT,     16'd0,     16'd0,     8'h00, 1'b0, 4'd0,  3'd0, 1'b1, 1'b1,
              "\033[?1049h"},
            '{MODE_ALT,     16'd65534, 16'd65534, 8'hFF, 1'b1, 4'd15, 3'd7, 1'b0, 1'b1,
              "\033[?1049l"},
            // The ignored property must not disturb the remembered cursor.
            '{MODE_IGNORE,  16'd3,     16'd3,     8'hFF, 1'b1, 4'd15, 3'd7, 1'b1, 1'b1, ""},
            '{MODE_CURSOR,  16'd65534, 16'd0,     8'h00, 1'b0, 4'd0,  3'd0, 1'b0, 1'b1, ""},
            // Forget with noise in every field, then the home cell is sent again.
            '{MODE_FORGET,  16'd65534, 16'd65534, 8'hFF, 1'b1, 4'd15, 3'd7, 1'b1, 1'b1, ""},
            '{MODE_CURSOR,  16'd0,     16'd0,     8'h00, 1'b0, 4'd0,  3'd0, 1'b0, 1'b1, "\033[1;1H"}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send_op(script[i]);

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            // A stretch with no idling on either side.
            calm = (n >= 100 && n < 160);
            // Halfway through, hold off until the block has emptied.
            if (n == RANDOM_OPS / 2)
                drain();
            send_op(random_op());
        end
        calm = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d operations (%0d scripted), %0d of them silent.",
                 ops_sent, script.size(), silent_ops);
        $display("Checked %0d output bytes over %0d cycles.", bytes_checked, cycle_count);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
